/* sv/bptq_pkg.sv */
package bptq_pkg;

	localparam int DEPTH     = 1024;
	localparam int MAX_BATCH = 64;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_TICK  = 2'd1,
		OP_PURGE = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_CAPACITY = 2'd0,
		REG_BATCH    = 2'd1,
		REG_MAX_AGE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] priority_req;
		logic [2:0]         task_kind;
		logic [31:0]        task_payload;
		logic [31:0]        time_ms;
	} in_t;

	typedef struct packed {
		logic               has_task;
		logic [2:0]         out_kind;
		logic signed [15:0] out_priority;
		logic [31:0]        out_payload;
		logic [31:0]        out_time;
		logic               last;
		logic [10:0]        queue_count;
		logic               overloaded;
		logic               evicted;
		logic [1:0]         load_level;
	} out_t;

	typedef struct packed {
		logic signed [15:0] pri;
		logic [2:0]         kind;
		logic [31:0]        payload;
		logic [31:0]        tstamp;
	} entry_t;

	typedef struct packed {
		logic latch;
		logic add_init;
		logic add_rd;
		logic add_move;
		logic add_put;
		logic tick_init;
		logic tick_rd;
		logic tick_load;
		logic purge_init;
		logic purge_rd;
		logic purge_step;
		logic purge_end;
		logic clear;
		logic fin_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       rem_zero;
		logic       rem_one;
		logic       init_zero;
		logic       shift_up;
		logic       out_busy;
	} sts_t;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

endpackage

/* sv/bounded_priority_task_queue.sv */
// Add: walks from the tail past each entry of lower priority, moving it up one slot, and stops
// on an entry of equal or higher priority.
// Tick: per dispatched task, a RAM read, then an output load; purge walks every entry.
// Clear empties the queue. One request at a time; the next is taken once the controller is idle.
// The entry store is one single-port-write RAM kept as a ring; its contents are not reset.
// arst_n clears count, ring pointers and output valid, and loads the register defaults.
module bounded_priority_task_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bptq_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output bptq_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);
	import bptq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bptq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bptq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* sv/bptq_ram.sv */
module bptq_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/bptq_dp.sv */
module bptq_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  bptq_pkg::cmd_t  cmd,
	output bptq_pkg::sts_t  sts,
	input  bptq_pkg::in_t   in_data,
	input  logic            cfg_valid,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	output logic            out_valid,
	input  logic            out_stall,
	output bptq_pkg::out_t  out_data
);
	import bptq_pkg::*;

	logic [10:0]   cap_q;
	logic [6:0]    batch_q;
	logic [31:0]   max_age_q;
	logic [AW-1:0] head_q, tail_q, ptr_q, wp_q;
	logic [CW-1:0] count_q, rem_q, kept_q;
	in_t           item_q;
	logic          ev_q;
	logic          out_valid_q;
	out_t          out_q;

	entry_t        rdata, wdata, new_e;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;

	logic [CW-1:0] effcap;
	logic          do_evict;
	logic [CW-1:0] batch_eff, tick_n;
	logic [31:0]   age;

	out_t          tick_o, fin_o;

	bptq_ram #(.W($bits(entry_t)), .D(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (cap_q == '0) begin
			effcap = CW'(1);
		end else if (32'(cap_q) > DEPTH) begin
			effcap = CW'(DEPTH);
		end else begin
			effcap = CW'(cap_q);
		end
		do_evict = (count_q >= effcap) && (count_q != '0);
		batch_eff = (32'(batch_q) > MAX_BATCH) ? CW'(MAX_BATCH) : CW'(batch_q);
		tick_n = (batch_eff > count_q) ? count_q : batch_eff;
		age = item_q.time_ms - rdata.tstamp;
		new_e = '{pri: item_q.priority_req, kind: item_q.task_kind,
			payload: item_q.task_payload, tstamp: item_q.time_ms};
	end

	// status fields for a given count
	function automatic out_t status(input logic [CW-1:0] c, input logic [CW-1:0] cap);
		out_t          o;
		logic [CW+2:0] c5, cap4, capx;
		c5   = {3'b000, c} + {1'b0, c, 2'b00};
		cap4 = {1'b0, cap, 2'b00};
		capx = {3'b000, cap};
		o = '0;
		o.queue_count = 11'(c);
		o.overloaded  = c5 > cap4;
		o.load_level  = (c5 > cap4) ? 2'd2 : ((c5 < capx) ? 2'd0 : 2'd1);
		return o;
	endfunction

	always_comb begin
		tick_o              = status(count_q - CW'(1), effcap);
		tick_o.has_task     = 1'b1;
		tick_o.out_kind     = rdata.kind;
		tick_o.out_priority = rdata.pri;
		tick_o.out_payload  = rdata.payload;
		tick_o.out_time     = rdata.tstamp;
		tick_o.last         = (rem_q == CW'(1));
		fin_o               = status(count_q, effcap);
		fin_o.last          = 1'b1;
		fin_o.evicted       = ev_q;
	end

	always_comb begin
		re    = cmd.add_rd | cmd.tick_rd | cmd.purge_rd;
		raddr = cmd.add_rd ? ptr_prev(ptr_q) : (cmd.tick_rd ? head_q : ptr_q);
		we    = cmd.add_move | cmd.add_put
			| (cmd.purge_step && (age < max_age_q));
		waddr = cmd.purge_step ? wp_q : ptr_q;
		wdata = cmd.add_put ? new_e : rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= 11'd1000;
			batch_q     <= 7'd10;
			max_age_q   <= 32'd30000;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_CAPACITY: cap_q     <= cfg_data[10:0];
					REG_BATCH:    batch_q   <= cfg_data[6:0];
					REG_MAX_AGE:  max_age_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.latch) begin
				item_q <= in_data;
				ev_q   <= 1'b0;
			end
			if (cmd.add_init) begin
				ptr_q <= tail_q;
				if (do_evict) begin
					head_q  <= ptr_next(head_q);
					count_q <= count_q - CW'(1);
					rem_q   <= count_q - CW'(1);
					ev_q    <= 1'b1;
				end else begin
					rem_q <= count_q;
				end
			end
			if (cmd.add_move) begin
				ptr_q <= ptr_prev(ptr_q);
				rem_q <= rem_q - CW'(1);
			end
			if (cmd.add_put) begin
				tail_q  <= ptr_next(tail_q);
				count_q <= count_q + CW'(1);
			end
			if (cmd.tick_init) begin
				rem_q <= tick_n;
			end
			if (cmd.tick_load) begin
				head_q      <= ptr_next(head_q);
				count_q     <= count_q - CW'(1);
				rem_q       <= rem_q - CW'(1);
				out_q       <= tick_o;
				out_valid_q <= 1'b1;
			end
			if (cmd.purge_init) begin
				ptr_q  <= head_q;
				wp_q   <= head_q;
				rem_q  <= count_q;
				kept_q <= '0;
			end
			if (cmd.purge_step) begin
				ptr_q <= ptr_next(ptr_q);
				rem_q <= rem_q - CW'(1);
				if (age < max_age_q) begin
					wp_q   <= ptr_next(wp_q);
					kept_q <= kept_q + CW'(1);
				end
			end
			if (cmd.purge_end) begin
				tail_q  <= wp_q;
				count_q <= kept_q;
			end
			if (cmd.clear) begin
				tail_q  <= head_q;
				count_q <= '0;
			end
			if (cmd.fin_load) begin
				out_q       <= fin_o;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_comb begin
		sts.op        = item_q.op;
		sts.rem_zero  = (rem_q == '0);
		sts.rem_one   = (rem_q == CW'(1));
		sts.init_zero = (tick_n == '0);
		sts.shift_up  = item_q.priority_req > rdata.pri;
		sts.out_busy  = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/bptq_ctrl.sv */
module bptq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bptq_pkg::sts_t sts,
	output bptq_pkg::cmd_t cmd
);
	import bptq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_A_CHK, S_A_CMP, S_T_RD, S_T_LD,
		S_P_CHK, S_P_CMP, S_FIN
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (op_t'(sts.op))
					OP_ADD: begin
						cmd.add_init = 1'b1;
						state_d      = S_A_CHK;
					end
					OP_TICK: begin
						cmd.tick_init = 1'b1;
						state_d       = sts.init_zero ? S_FIN : S_T_RD;
					end
					OP_PURGE: begin
						cmd.purge_init = 1'b1;
						state_d        = S_P_CHK;
					end
					default: begin
						cmd.clear = 1'b1;
						state_d   = S_FIN;
					end
				endcase
			end
			S_A_CHK: begin
				if (sts.rem_zero) begin
					cmd.add_put = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.add_rd = 1'b1;
					state_d    = S_A_CMP;
				end
			end
			S_A_CMP: begin
				if (sts.shift_up) begin
					cmd.add_move = 1'b1;
					state_d      = S_A_CHK;
				end else begin
					cmd.add_put = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_T_RD: begin
				cmd.tick_rd = 1'b1;
				state_d     = S_T_LD;
			end
			S_T_LD: begin
				// hold the head read until the output register frees
				if (!sts.out_busy) begin
					cmd.tick_load = 1'b1;
					state_d       = sts.rem_one ? S_IDLE : S_T_RD;
				end
			end
			S_P_CHK: begin
				if (sts.rem_zero) begin
					cmd.purge_end = 1'b1;
					state_d       = S_FIN;
				end else begin
					cmd.purge_rd = 1'b1;
					state_d      = S_P_CMP;
				end
			end
			S_P_CMP: begin
				cmd.purge_step = 1'b1;
				state_d        = S_P_CHK;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.fin_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
